>>> rtl/amx_pkg.sv
// ----------------------------------------------------------------------------
// amx_pkg
// Shared constants, types and width helpers of the affine matrix inverse.
// ----------------------------------------------------------------------------
package amx_pkg;

  // default word and fraction widths, Q16.16
  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  // row index of the translation row, last of the four
  localparam logic [1:0] LAST_ROW = 2'd3;

  // per-row tag that travels with the divider data
  typedef struct packed {
    logic [1:0] row;
    logic       singular;
    logic       last;
  } meta_t;

  // width of the dividend and remainder in the divider
  function automatic int rem_bits(input int w, input int f);
    return 4 * w + 2 * f + 6;
  endfunction

endpackage

>>> rtl/amx_if.sv
// ----------------------------------------------------------------------------
// amx_in_if / amx_out_if
// Valid/ready channels carrying one affine matrix and one inverse row.
// ----------------------------------------------------------------------------
interface amx_in_if #(
  parameter int WORD_BITS = amx_pkg::WORD_BITS_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] a11, a12, a13;
  logic signed [WORD_BITS-1:0] a21, a22, a23;
  logic signed [WORD_BITS-1:0] a31, a32, a33;
  logic signed [WORD_BITS-1:0] tx, ty, tz;

  modport source (
    output valid, a11, a12, a13, a21, a22, a23, a31, a32, a33, tx, ty, tz,
    input  ready
  );
  modport sink (
    input  valid, a11, a12, a13, a21, a22, a23, a31, a32, a33, tx, ty, tz,
    output ready
  );
endinterface

interface amx_out_if #(
  parameter int WORD_BITS = amx_pkg::WORD_BITS_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic [1:0]                  row_number;
  logic signed [WORD_BITS-1:0] col_one;
  logic signed [WORD_BITS-1:0] col_two;
  logic signed [WORD_BITS-1:0] col_three;
  logic                        singular;
  logic                        last_row;

  modport source (
    output valid, row_number, col_one, col_two, col_three, singular, last_row,
    input  ready
  );
  modport sink (
    input  valid, row_number, col_one, col_two, col_three, singular, last_row,
    output ready
  );
endinterface

>>> rtl/amx_divpipe.sv
// ----------------------------------------------------------------------------
// amx_divpipe
// Three-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module amx_divpipe #(
  parameter int WORD_BITS = amx_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = amx_pkg::FRAC_BITS_DEF,
  localparam int XW = amx_pkg::rem_bits(WORD_BITS, FRAC_BITS),
  localparam int QW = WORD_BITS + 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  vld_i,
  input  logic [2:0][XW-1:0]    x_i,
  input  logic [XW-1:0]         y_i,
  input  logic [2:0]            neg_i,
  input  amx_pkg::meta_t        meta_i,
  output logic                  vld_o,
  output logic [2:0][QW-1:0]    q_o,
  output logic [2:0]            neg_o,
  output amx_pkg::meta_t        meta_o
);

  logic           vld_q  [QW+1];
  logic [XW-1:0]  y_q    [QW+1];
  logic [XW-1:0]  r_q    [QW+1][3];
  logic [QW-1:0]  q_q    [QW+1][3];
  logic [2:0]     neg_q  [QW+1];
  amx_pkg::meta_t meta_q [QW+1];

  // stage zero is the input
  always_comb begin
    vld_q[0]  = vld_i;
    y_q[0]    = y_i;
    neg_q[0]  = neg_i;
    meta_q[0] = meta_i;
    for (int l = 0; l < 3; l++) begin
      r_q[0][l] = x_i[l];
      q_q[0][l] = '0;
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int K = QW - 1 - s;
    logic [XW-1:0] ysh;
    logic [XW:0]   diff [3];
    logic [2:0]    ge;

    // trial subtract of the shifted divisor
    always_comb begin
      ysh = y_q[s] << K;
      for (int l = 0; l < 3; l++) begin
        diff[l] = {1'b0, r_q[s][l]} - {1'b0, ysh};
        ge[l]   = !diff[l][XW];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    // bit K of the quotient is still clear on entry to this stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        y_q[s+1]    <= y_q[s];
        neg_q[s+1]  <= neg_q[s];
        meta_q[s+1] <= meta_q[s];
        for (int l = 0; l < 3; l++) begin
          r_q[s+1][l] <= ge[l] ? diff[l][XW-1:0] : r_q[s][l];
          q_q[s+1][l] <= q_q[s][l] | (QW'(ge[l]) << K);
        end
      end
    end
  end

  always_comb begin
    vld_o  = vld_q[QW];
    neg_o  = neg_q[QW];
    meta_o = meta_q[QW];
    for (int l = 0; l < 3; l++) begin
      q_o[l] = q_q[QW][l];
    end
  end

endmodule

>>> rtl/affine_matrix_inverse.sv
// ----------------------------------------------------------------------------
// affine_matrix_inverse
// Inverse of an affine 4x3 matrix in signed fixed point, four rows per matrix.
// ----------------------------------------------------------------------------
// channel  dir  payload                                        transfer when
// in_i     in   a11..a33, tx, ty, tz                           valid && ready
// out_o    out  row_number, col_one..col_three, singular,      valid && ready
//               last_row
//
// A row buffer issues one row per cycle, unless the back pipeline is frozen,
// into three shared divider lanes; the next matrix loads as the last row issues.
// The path from input transfer to first row runs through 6 front stages, the
// row buffer, 2 setup stages, WORD_BITS + 2 divider stages and the output
// register.
// Reset clears only the valid bits and the row counter.
// Low out_o.ready with a row held at the output freezes the back pipeline; a
// full row buffer then freezes the front stages and drops in_i.ready.
// ----------------------------------------------------------------------------
module affine_matrix_inverse #(
  parameter int WORD_BITS = amx_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = amx_pkg::FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  amx_in_if.sink    in_i,
  amx_out_if.source out_o
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int CW = 2 * W + 1;
  localparam int PW = 3 * W + 1;
  localparam int DW = 3 * W + 3;
  localparam int XW = amx_pkg::rem_bits(W, F);
  localparam int QW = W + 2;

  // operand pairs of each adjugate entry, flat index row*3+col
  localparam int CfIdx [9][4] = '{
    '{4, 8, 7, 5}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{3, 2, 0, 5},
    '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}
  };

  logic front_en, back_en, take;

  // front valid bits
  logic f1_vld_q, f2_vld_q, f3_vld_q, f4_vld_q, f5_vld_q, f6_vld_q;

  // front payload
  logic signed [W-1:0]  a_q   [9];
  logic signed [W-1:0]  t1_q  [3];
  logic signed [2*W-1:0] pa_q [9];
  logic signed [2*W-1:0] pb_q [9];
  logic signed [W-1:0]  ac2_q [3];
  logic signed [W-1:0]  t2_q  [3];
  logic signed [CW-1:0] cf3_q [9];
  logic signed [W-1:0]  ac3_q [3];
  logic signed [W-1:0]  t3_q  [3];
  logic signed [CW-1:0] cf4_q [9];
  logic signed [2*W:0]  pdh_q [3];
  logic signed [2*W:0]  pdl_q [3];
  logic signed [2*W:0]  pah_q [9];
  logic signed [2*W:0]  pal_q [9];
  logic signed [CW-1:0] cf5_q [9];
  logic signed [PW-1:0] dt_q  [3];
  logic signed [PW-1:0] at_q  [9];
  logic signed [CW-1:0] cf6_q [9];
  logic signed [DW-1:0] det6_q;
  logic signed [DW-1:0] acc6_q [3];

  // row buffer
  logic                 sv_q;
  logic [1:0]           rcnt_q;
  logic signed [CW-1:0] cfs_q  [9];
  logic signed [DW-1:0] dets_q;
  logic signed [DW-1:0] accs_q [3];

  // setup stages
  logic                 b1_vld_q, b2_vld_q;
  logic [DW-1:0]        nm_q [3];
  logic [DW-1:0]        dm_q;
  logic [2:0]           neg1_q, neg2_q;
  logic                 r3_q;
  amx_pkg::meta_t       meta1_q, meta2_q;
  logic [2:0][XW-1:0]   x_q;
  logic [XW-1:0]        y_q;

  // divider outputs
  logic                 dv_vld;
  logic [2:0][QW-1:0]   dv_q;
  logic [2:0]           dv_neg;
  amx_pkg::meta_t       dv_meta;

  // output register
  logic                 out_vld_q;
  amx_pkg::meta_t       out_meta_q;
  logic signed [W-1:0]  col_q [3];

  // handshake control
  assign back_en  = !out_vld_q || out_o.ready;
  assign take     = !sv_q || (back_en && (rcnt_q == amx_pkg::LAST_ROW));
  assign front_en = !f6_vld_q || take;
  assign in_i.ready = front_en;

  // front valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
      f2_vld_q <= 1'b0;
      f3_vld_q <= 1'b0;
      f4_vld_q <= 1'b0;
      f5_vld_q <= 1'b0;
      f6_vld_q <= 1'b0;
    end else if (front_en) begin
      f1_vld_q <= in_i.valid;
      f2_vld_q <= f1_vld_q;
      f3_vld_q <= f2_vld_q;
      f4_vld_q <= f3_vld_q;
      f5_vld_q <= f4_vld_q;
      f6_vld_q <= f5_vld_q;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (front_en) begin
      a_q[0]  <= in_i.a11;
      a_q[1]  <= in_i.a12;
      a_q[2]  <= in_i.a13;
      a_q[3]  <= in_i.a21;
      a_q[4]  <= in_i.a22;
      a_q[5]  <= in_i.a23;
      a_q[6]  <= in_i.a31;
      a_q[7]  <= in_i.a32;
      a_q[8]  <= in_i.a33;
      t1_q[0] <= in_i.tx;
      t1_q[1] <= in_i.ty;
      t1_q[2] <= in_i.tz;
    end
  end

  // cofactor products
  always_ff @(posedge clk_i) begin
    if (front_en) begin
      for (int c = 0; c < 9; c++) begin
        pa_q[c] <= a_q[CfIdx[c][0]] * a_q[CfIdx[c][1]];
        pb_q[c] <= a_q[CfIdx[c][2]] * a_q[CfIdx[c][3]];
      end
      for (int i = 0; i < 3; i++) begin
        ac2_q[i] <= a_q[3*i];
        t2_q[i]  <= t1_q[i];
      end
    end
  end

  // cofactor differences
  always_ff @(posedge clk_i) begin
    if (front_en) begin
      for (int c = 0; c < 9; c++) begin
        cf3_q[c] <= CW'(pa_q[c]) - CW'(pb_q[c]);
      end
      ac3_q <= ac2_q;
      t3_q  <= t2_q;
    end
  end

  // split partial products for determinant and translation sums
  always_ff @(posedge clk_i) begin
    if (front_en) begin
      for (int i = 0; i < 3; i++) begin
        pdh_q[i] <= ac3_q[i] * $signed(cf3_q[i][CW-1:W]);
        pdl_q[i] <= ac3_q[i] * $signed({1'b0, cf3_q[i][W-1:0]});
        for (int j = 0; j < 3; j++) begin
          pah_q[3*i+j] <= t3_q[i] * $signed(cf3_q[3*i+j][CW-1:W]);
          pal_q[3*i+j] <= t3_q[i] * $signed({1'b0, cf3_q[3*i+j][W-1:0]});
        end
      end
      cf4_q <= cf3_q;
    end
  end

  // recombine the halves of each product
  always_ff @(posedge clk_i) begin
    if (front_en) begin
      for (int i = 0; i < 3; i++) begin
        dt_q[i] <= (PW'(pdh_q[i]) <<< W) + PW'(pdl_q[i]);
      end
      for (int c = 0; c < 9; c++) begin
        at_q[c] <= (PW'(pah_q[c]) <<< W) + PW'(pal_q[c]);
      end
      cf5_q <= cf4_q;
    end
  end

  // determinant and translation sums
  always_ff @(posedge clk_i) begin
    if (front_en) begin
      det6_q <= DW'(dt_q[0]) + DW'(dt_q[1]) + DW'(dt_q[2]);
      for (int j = 0; j < 3; j++) begin
        acc6_q[j] <= DW'(at_q[j]) + DW'(at_q[3+j]) + DW'(at_q[6+j]);
      end
      cf6_q <= cf5_q;
    end
  end

  // row buffer control, one row issued per back-pipe advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q   <= 1'b0;
      rcnt_q <= '0;
    end else if (take) begin
      sv_q   <= f6_vld_q;
      rcnt_q <= '0;
    end else if (back_en) begin
      rcnt_q <= rcnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cfs_q  <= cf6_q;
      dets_q <= det6_q;
      accs_q <= acc6_q;
    end
  end

  // row select and magnitudes
  logic signed [DW-1:0] num [3];
  logic [DW-1:0]        nmag [3];
  logic [2:0]           nneg;
  logic                 row3;

  always_comb begin
    row3 = (rcnt_q == amx_pkg::LAST_ROW);
    for (int j = 0; j < 3; j++) begin
      case (rcnt_q)
        2'd0:    num[j] = DW'(cfs_q[j]);
        2'd1:    num[j] = DW'(cfs_q[3+j]);
        2'd2:    num[j] = DW'(cfs_q[6+j]);
        default: num[j] = accs_q[j];
      endcase
      nmag[j] = num[j][DW-1] ? DW'(-num[j]) : DW'(num[j]);
      nneg[j] = num[j][DW-1] ^ dets_q[DW-1] ^ row3;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_vld_q <= 1'b0;
      b2_vld_q <= 1'b0;
    end else if (back_en) begin
      b1_vld_q <= sv_q;
      b2_vld_q <= b1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (back_en) begin
      nm_q             <= nmag;
      dm_q             <= dets_q[DW-1] ? DW'(-dets_q) : DW'(dets_q);
      neg1_q           <= nneg;
      r3_q             <= row3;
      meta1_q.row      <= rcnt_q;
      meta1_q.singular <= (dets_q == '0);
      meta1_q.last     <= row3;
    end
  end

  // rounded dividend 2|n|*2^shift + |d| and divisor 2|d|
  always_ff @(posedge clk_i) begin
    if (back_en) begin
      for (int j = 0; j < 3; j++) begin
        x_q[j] <= r3_q ? (XW'(nm_q[j]) << (F + 1)) + XW'(dm_q)
                       : (XW'(nm_q[j]) << (2 * F + 1)) + XW'(dm_q);
      end
      y_q     <= XW'(dm_q) << 1;
      neg2_q  <= neg1_q;
      meta2_q <= meta1_q;
    end
  end

  amx_divpipe #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_divpipe (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (back_en),
    .vld_i  (b2_vld_q),
    .x_i    (x_q),
    .y_i    (y_q),
    .neg_i  (neg2_q),
    .meta_i (meta2_q),
    .vld_o  (dv_vld),
    .q_o    (dv_q),
    .neg_o  (dv_neg),
    .meta_o (dv_meta)
  );

  // saturation and sign
  logic [QW-1:0] lim [3];
  logic [QW-1:0] qs  [3];
  logic [QW-1:0] qv  [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      lim[j] = dv_neg[j] ? (QW'(1) << (W - 1)) : (QW'(1) << (W - 1)) - QW'(1);
      qs[j]  = (dv_q[j] > lim[j]) ? lim[j] : dv_q[j];
      qv[j]  = dv_neg[j] ? QW'(-qs[j]) : qs[j];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (back_en) begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (back_en) begin
      out_meta_q <= dv_meta;
      for (int j = 0; j < 3; j++) begin
        col_q[j] <= dv_meta.singular ? '0 : $signed(qv[j][W-1:0]);
      end
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.row_number = out_meta_q.row;
  assign out_o.col_one    = col_q[0];
  assign out_o.col_two    = col_q[1];
  assign out_o.col_three  = col_q[2];
  assign out_o.singular   = out_meta_q.singular;
  assign out_o.last_row   = out_meta_q.last;

`ifndef NO_ASSERTIONS
  // last_row tag agrees with the row index carried down the divider
  a_last_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.last_row == (out_o.row_number == amx_pkg::LAST_ROW)))
    else $error("last_row tag does not match row number");

  // singular rows carry zero columns
  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.singular |->
      (out_o.col_one == '0) && (out_o.col_two == '0) && (out_o.col_three == '0))
    else $error("singular row with nonzero columns");

  // a loaded matrix starts issuing at row zero
  a_load_row0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && f6_vld_q |=> sv_q && (rcnt_q == '0))
    else $error("row buffer load did not restart at row zero");

  // a matrix waiting on the row buffer is not dropped
  a_front_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f6_vld_q && !front_en |=> f6_vld_q)
    else $error("front stage lost a matrix while stalled");
`endif

endmodule
